// File: hdl/llcsnap_pkg.sv
// LLC/SNAP header parser: shared types and constants.
// Used by llcsnap_parse, llcsnap_queue and llc_snap_header_parser_core.
`default_nettype none

package llcsnap_pkg;

    localparam logic [7:0]  SNAP_SAP   = 8'hAA;
    localparam logic [15:0] TYPE_EAPOL = 16'h888E;
    localparam logic [15:0] TYPE_IPV4  = 16'h0800;

    localparam logic        KIND_HDR     = 1'b0;
    localparam logic        KIND_PAYLOAD = 1'b1;

    localparam logic [1:0]  FMT_INFO  = 2'd0;
    localparam logic [1:0]  FMT_SUPER = 2'd1;
    localparam logic [1:0]  FMT_UNNUM = 2'd2;

    localparam logic [1:0]  CLASS_OTHER = 2'd0;
    localparam logic [1:0]  CLASS_EAPOL = 2'd1;
    localparam logic [1:0]  CLASS_IPV4  = 2'd2;

    localparam int unsigned QUEUE_DEPTH = 4;

    typedef struct packed {
        logic        kind;
        logic [7:0]  dsap;
        logic [7:0]  ssap;
        logic [15:0] control_word;
        logic [1:0]  frame_format;
        logic        snap_flag;
        logic [23:0] snap_oui;
        logic [15:0] snap_pid;
        logic [1:0]  protocol_class;
        logic [7:0]  payload_byte;
        logic        last_flag;
        logic        truncated;
    } result_t;

    typedef struct packed {
        logic emit;
        logic header_done;
    } parse_status_t;

endpackage

`default_nettype wire

// File: hdl/llcsnap_parse.sv
// Front end: takes frame bytes, tracks header fields, forms result items.
// Depends on llcsnap_pkg.
`default_nettype none

module llcsnap_parse
    import llcsnap_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    data_byte,
    input  wire logic          frame_end,
    output result_t            result,
    output parse_status_t      status
);

    logic [3:0]  pos_reg, pos_next;
    logic        hdr_done_reg, hdr_done_next;
    logic [7:0]  dsap_reg, dsap_next;
    logic [7:0]  ssap_reg, ssap_next;
    logic [15:0] ctrl_reg, ctrl_next;
    logic        two_reg, two_next;
    logic [1:0]  fmt_reg, fmt_next;
    logic [23:0] org_reg, org_next;
    logic [15:0] type_reg, type_next;

    logic [3:0]  org_start;
    logic [3:0]  k;
    logic [3:0]  pos_inc;
    logic [3:0]  hlen;
    logic        snap;
    logic        complete;
    logic        clear;

    always_comb
    begin
        dsap_next = dsap_reg;
        ssap_next = ssap_reg;
        ctrl_next = ctrl_reg;
        two_next  = two_reg;
        fmt_next  = fmt_reg;
        org_next  = org_reg;
        type_next = type_reg;
        org_start = two_reg ? 4'd4 : 4'd3;
        k         = pos_reg - org_start;

        if (pos_reg == 4'd0)
        begin
            dsap_next = data_byte;
        end
        else if (pos_reg == 4'd1)
        begin
            ssap_next = data_byte;
        end
        else if (pos_reg == 4'd2)
        begin
            ctrl_next = {8'h00, data_byte};
            case (data_byte[1:0]) inside
                2'b00, 2'b10:
                begin
                    two_next = 1'b1;
                    fmt_next = FMT_INFO;
                end
                2'b01:
                begin
                    two_next = 1'b1;
                    fmt_next = FMT_SUPER;
                end
                default:
                begin
                    two_next = 1'b0;
                    fmt_next = FMT_UNNUM;
                end
            endcase
        end
        else if (pos_reg == 4'd3 && two_reg)
        begin
            ctrl_next = ctrl_reg | {data_byte, 8'h00};
        end
        else if (pos_reg >= org_start)
        begin
            case (k)
                4'd0:    org_next  = org_reg | {data_byte, 16'h0000};
                4'd1:    org_next  = org_reg | {8'h00, data_byte, 8'h00};
                4'd2:    org_next  = org_reg | {16'h0000, data_byte};
                4'd3:    type_next = type_reg | {data_byte, 8'h00};
                4'd4:    type_next = type_reg | {8'h00, data_byte};
                default: ;
            endcase
        end

        pos_inc  = (pos_reg < 4'd15) ? pos_reg + 4'd1 : pos_reg;
        snap     = (pos_inc >= 4'd2) && (dsap_next == SNAP_SAP) && (ssap_next == SNAP_SAP);
        hlen     = 4'd2 + (two_next ? 4'd2 : 4'd1) + (snap ? 4'd5 : 4'd0);
        complete = (pos_inc >= 4'd3) && (pos_inc == hlen);
    end

    // result item
    always_comb
    begin
        result = '0;
        if (hdr_done_reg)
        begin
            result.kind         = KIND_PAYLOAD;
            result.payload_byte = data_byte;
            result.last_flag    = frame_end;
        end
        else
        begin
            result.kind         = KIND_HDR;
            result.dsap         = dsap_next;
            result.ssap         = ssap_next;
            result.control_word = ctrl_next;
            result.frame_format = fmt_next;
            result.snap_flag    = snap;
            result.snap_oui     = snap ? org_next : 24'h000000;
            result.snap_pid     = snap ? type_next : 16'h0000;
            if (snap && complete && type_next == TYPE_EAPOL)
                result.protocol_class = CLASS_EAPOL;
            else if (snap && complete && type_next == TYPE_IPV4)
                result.protocol_class = CLASS_IPV4;
            else
                result.protocol_class = CLASS_OTHER;
            result.last_flag    = frame_end;
            result.truncated    = !complete;
        end
        status.emit        = hdr_done_reg || complete || frame_end;
        status.header_done = hdr_done_reg;
    end

    assign clear         = frame_end;
    assign hdr_done_next = hdr_done_reg || complete;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            hdr_done_reg <= 1'b0;
            dsap_reg     <= '0;
            ssap_reg     <= '0;
            ctrl_reg     <= '0;
            two_reg      <= 1'b0;
            fmt_reg      <= '0;
            org_reg      <= '0;
            type_reg     <= '0;
        end
        else if (accept)
        begin
            if (clear)
            begin
                pos_reg      <= '0;
                hdr_done_reg <= 1'b0;
                dsap_reg     <= '0;
                ssap_reg     <= '0;
                ctrl_reg     <= '0;
                two_reg      <= 1'b0;
                fmt_reg      <= '0;
                org_reg      <= '0;
                type_reg     <= '0;
            end
            else if (!hdr_done_reg)
            begin
                pos_reg      <= pos_inc;
                hdr_done_reg <= hdr_done_next;
                dsap_reg     <= dsap_next;
                ssap_reg     <= ssap_next;
                ctrl_reg     <= ctrl_next;
                two_reg      <= two_next;
                fmt_reg      <= fmt_next;
                org_reg      <= org_next;
                type_reg     <= type_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/llcsnap_queue.sv
// Back end: short result queue between parser and the result ports.
// Depends on llcsnap_pkg.
`default_nettype none

module llcsnap_queue
    import llcsnap_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    wr_en,
    input  wire result_t wr_data,
    input  wire logic    rd_en,
    output result_t      rd_data,
    output logic         full,
    output logic         empty,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

    result_t       store [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign level = count_reg;
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + PW'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + PW'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + CW'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            store[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/llc_snap_header_parser_core.sv
// Top level of the 802.2 LLC/SNAP header parser: parser front end plus result queue.
// Depends on llcsnap_pkg, llcsnap_parse and llcsnap_queue.
//
// Frame bytes are pushed one per clock. Each accepted byte is parsed in the cycle
// it is taken and yields zero or one result item, written straight into a
// QUEUE_DEPTH-entry queue; if it was empty, a result is at the ports the cycle after
// its byte was accepted. The block takes one byte every cycle as long as the queue
// has room, so it sustains one item per clock while results are popped at that rate;
// full rises only once QUEUE_DEPTH results are waiting. Header bytes produce a single
// descriptor item when the header completes (or a truncated one when the frame ends
// early); every byte after the header produces a payload item.
`default_nettype none

module llc_snap_header_parser_core
    import llcsnap_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    input  wire logic        frame_end,
    output logic             empty,
    input  wire logic        pop,
    output logic             kind,
    output logic [7:0]       dsap,
    output logic [7:0]       ssap,
    output logic [15:0]      control_word,
    output logic [1:0]       frame_format,
    output logic             snap_flag,
    output logic [23:0]      snap_oui,
    output logic [15:0]      snap_pid,
    output logic [1:0]       protocol_class,
    output logic [7:0]       payload_byte,
    output logic             last_flag,
    output logic             truncated
);

    localparam int unsigned CW = $clog2(QUEUE_DEPTH_P + 1);

    result_t         parse_result;
    result_t         head;
    parse_status_t   status;
    logic            in_accept;
    logic [CW-1:0]   level;

    assign in_accept = push && !full;

    llcsnap_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .data_byte (data_byte),
        .frame_end (frame_end),
        .result    (parse_result),
        .status    (status)
    );

    llcsnap_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_accept && status.emit),
        .wr_data (parse_result),
        .rd_en   (pop),
        .rd_data (head),
        .full    (full),
        .empty   (empty),
        .level   (level)
    );

    assign kind           = head.kind;
    assign dsap           = head.dsap;
    assign ssap           = head.ssap;
    assign control_word   = head.control_word;
    assign frame_format   = head.frame_format;
    assign snap_flag      = head.snap_flag;
    assign snap_oui       = head.snap_oui;
    assign snap_pid       = head.snap_pid;
    assign protocol_class = head.protocol_class;
    assign payload_byte   = head.payload_byte;
    assign last_flag      = head.last_flag;
    assign truncated      = head.truncated;

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= CW'(QUEUE_DEPTH_P))
        else $error("queue level above depth");

    a_payload_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && status.header_done) |-> status.emit)
        else $error("payload byte produced no item");

    a_hdr_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !status.header_done && status.emit && !parse_result.truncated
         && !frame_end) |=> status.header_done)
        else $error("complete header did not enter payload phase");

    a_truncated_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && status.emit && parse_result.truncated) |-> parse_result.last_flag)
        else $error("truncated descriptor without last flag");

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Testbench for llc_snap_header_parser_core: streams LLC/SNAP frames byte by byte
// and checks every descriptor and payload item against a built-in parser model.
// Depends on llcsnap_pkg and the llc_snap_header_parser_core RTL.
`default_nettype none

module testbench
    import llcsnap_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         wait_drain;
    } frame_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  data_byte = 8'h00;
    logic        frame_end = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic        kind;
    logic [7:0]  dsap;
    logic [7:0]  ssap;
    logic [15:0] control_word;
    logic [1:0]  frame_format;
    logic        snap_flag;
    logic [23:0] snap_oui;
    logic [15:0] snap_pid;
    logic [1:0]  protocol_class;
    logic [7:0]  payload_byte;
    logic        last_flag;
    logic        truncated;

    llc_snap_header_parser_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .frame_end      (frame_end),
        .empty          (empty),
        .pop            (pop),
        .kind           (kind),
        .dsap           (dsap),
        .ssap           (ssap),
        .control_word   (control_word),
        .frame_format   (frame_format),
        .snap_flag      (snap_flag),
        .snap_oui       (snap_oui),
        .snap_pid       (snap_pid),
        .protocol_class (protocol_class),
        .payload_byte   (payload_byte),
        .last_flag      (last_flag),
        .truncated      (truncated)
    );

    frame_byte_t tx_bytes[$];
    result_t     pending_results[$];
    bit          drain_next = 1'b0;
    int unsigned mismatches = 0;
    int unsigned send_gap = 0;
    int unsigned pop_stall = 0;
    int unsigned send_idle_pct = 0;
    int unsigned pop_idle_pct = 0;
    int unsigned bytes_taken = 0;
    int unsigned results_seen = 0;

    // parser state
    logic [3:0]  hdr_pos;
    logic        in_payload;
    logic [7:0]  got_dsap;
    logic [7:0]  got_ssap;
    logic [15:0] got_ctrl;
    logic        ctrl_two;
    logic [1:0]  got_fmt;
    logic [23:0] got_org;
    logic [15:0] got_type;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic void clear_parser();
        hdr_pos    = '0;
        in_payload = 1'b0;
        got_dsap   = '0;
        got_ssap   = '0;
        got_ctrl   = '0;
        ctrl_two   = 1'b0;
        got_fmt    = FMT_INFO;
        got_org    = '0;
        got_type   = '0;
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic last);
        result_t     r;
        int unsigned ctl_len;
        int unsigned hdr_len;
        int unsigned k;
        logic        snap;
        r = '0;
        if (in_payload) begin
            r.kind         = KIND_PAYLOAD;
            r.payload_byte = b;
            r.last_flag    = last;
            pending_results.push_back(r);
            if (last)
                clear_parser();
        end else begin
            ctl_len = ctrl_two ? 2 : 1;
            if (hdr_pos == 0) begin
                got_dsap = b;
            end else if (hdr_pos == 1) begin
                got_ssap = b;
            end else if (hdr_pos == 2) begin
                got_ctrl = {8'h00, b};
                if (b[0] == 1'b0) begin
                    ctrl_two = 1'b1;
                    got_fmt  = FMT_INFO;
                end else if (b[1:0] == 2'b01) begin
                    ctrl_two = 1'b1;
                    got_fmt  = FMT_SUPER;
                end else begin
                    ctrl_two = 1'b0;
                    got_fmt  = FMT_UNNUM;
                end
            end else if (hdr_pos == 3 && ctrl_two) begin
                got_ctrl[15:8] = b;
            end else if (hdr_pos >= 2 + ctl_len) begin
                k = hdr_pos - 2 - ctl_len;
                if (k < 3)
                    got_org[8 * (2 - k) +: 8] = b;
                else if (k < 5)
                    got_type[8 * (4 - k) +: 8] = b;
            end
            if (hdr_pos < 15)
                hdr_pos = hdr_pos + 4'd1;

            snap    = hdr_pos >= 2 && got_dsap == SNAP_SAP && got_ssap == SNAP_SAP;
            ctl_len = ctrl_two ? 2 : 1;
            hdr_len = 2 + ctl_len + (snap ? 5 : 0);

            if ((hdr_pos >= 3 && hdr_pos == hdr_len) || last) begin
                r.kind         = KIND_HDR;
                r.dsap         = got_dsap;
                r.ssap         = got_ssap;
                r.control_word = got_ctrl;
                r.frame_format = got_fmt;
                r.snap_flag    = snap;
                r.snap_oui     = snap ? got_org : '0;
                r.snap_pid     = snap ? got_type : '0;
                r.truncated    = !(hdr_pos >= 3 && hdr_pos == hdr_len);
                r.last_flag    = last;
                r.protocol_class = CLASS_OTHER;
                if (snap && !r.truncated) begin
                    if (got_type == TYPE_EAPOL)
                        r.protocol_class = CLASS_EAPOL;
                    else if (got_type == TYPE_IPV4)
                        r.protocol_class = CLASS_IPV4;
                end
                pending_results.push_back(r);
                if (last)
                    clear_parser();
                else
                    in_payload = 1'b1;
            end
        end
    endfunction

    function automatic void cmp_field(input string name, input logic [23:0] want,
                                      input logic [23:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic int unsigned pick_idle_pct();
        case ($urandom_range(4))
            0, 1:    return 0;
            2:       return 5;
            3:       return 20;
            default: return 50;
        endcase
    endfunction

    task automatic add_frame(input logic [7:0] bytes[$]);
        frame_byte_t fb;
        foreach (bytes[i]) begin
            fb.data       = bytes[i];
            fb.last       = (i == bytes.size() - 1);
            fb.wait_drain = (i == 0) && drain_next;
            tx_bytes.push_back(fb);
        end
        drain_next = 1'b0;
    endtask

    task automatic add_random_frame();
        logic [7:0]  fr[$];
        logic [7:0]  ctl;
        logic [15:0] etype;
        int unsigned sel;
        int unsigned n;
        bit          snap;
        sel = $urandom_range(99);
        drain_next = ($urandom_range(99) < 3);
        if (sel < 8) begin
            n = $urandom_range(12, 1);
            repeat (n) fr.push_back(8'($urandom));
        end else begin
            snap = (sel < 65);
            fr.push_back((snap || $urandom_range(3) == 0) ? SNAP_SAP : 8'($urandom));
            fr.push_back((snap || $urandom_range(3) == 0) ? SNAP_SAP : 8'($urandom));
            ctl = 8'($urandom);
            case ($urandom_range(2))
                0:       ctl[0] = 1'b0;
                1:       ctl[1:0] = 2'b01;
                default: ctl[1:0] = 2'b11;
            endcase
            fr.push_back(ctl);
            if (ctl[1:0] != 2'b11)
                fr.push_back(8'($urandom));
            if (snap) begin
                if ($urandom_range(1) == 0) begin
                    repeat (3) fr.push_back(8'h00);
                end else begin
                    repeat (3) fr.push_back(8'($urandom));
                end
                case ($urandom_range(3))
                    0:       etype = TYPE_EAPOL;
                    1:       etype = TYPE_IPV4;
                    default: etype = 16'($urandom);
                endcase
                fr.push_back(etype[15:8]);
                fr.push_back(etype[7:0]);
            end
            if ($urandom_range(99) < 15) begin
                n = $urandom_range(fr.size() - 1, 1);
                fr = fr[0:n-1];
            end else begin
                n = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8);
                repeat (n) fr.push_back(8'($urandom));
            end
        end
        add_frame(fr);
    endtask

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            push      <= 1'b0;
            data_byte <= 8'h00;
            frame_end <= 1'b0;
        end else begin
            if (push && !full) begin
                parse_byte(data_byte, frame_end);
                void'(tx_bytes.pop_front());
                bytes_taken++;
                if (bytes_taken % 50 == 0)
                    send_idle_pct = (tx_bytes.size() < 150) ? 0 : pick_idle_pct();
            end
            if (tx_bytes.size() != 0 && tx_bytes[0].wait_drain && pending_results.size() == 0)
                tx_bytes[0].wait_drain = 1'b0;
            if (send_gap != 0) begin
                send_gap--;
                push <= 1'b0;
            end else if (tx_bytes.size() == 0 || tx_bytes[0].wait_drain) begin
                push <= 1'b0;
            end else if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
                send_gap = $urandom_range(17, 1) - 1;
                push <= 1'b0;
            end else begin
                push      <= 1'b1;
                data_byte <= tx_bytes[0].data;
                frame_end <= tx_bytes[0].last;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (pending_results.size() == 0) begin
                    $error("result item with nothing pending");
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    cmp_field("kind", want.kind, kind);
                    cmp_field("dsap", want.dsap, dsap);
                    cmp_field("ssap", want.ssap, ssap);
                    cmp_field("control_word", want.control_word, control_word);
                    cmp_field("frame_format", want.frame_format, frame_format);
                    cmp_field("snap_flag", want.snap_flag, snap_flag);
                    cmp_field("snap_oui", want.snap_oui, snap_oui);
                    cmp_field("snap_pid", want.snap_pid, snap_pid);
                    cmp_field("protocol_class", want.protocol_class, protocol_class);
                    cmp_field("payload_byte", want.payload_byte, payload_byte);
                    cmp_field("last_flag", want.last_flag, last_flag);
                    cmp_field("truncated", want.truncated, truncated);
                end
                results_seen++;
                if (results_seen % 40 == 0)
                    pop_idle_pct = (tx_bytes.size() < 150) ? 0 : pick_idle_pct();
            end
            if (pop_stall != 0) begin
                pop_stall--;
                pop <= 1'b0;
            end else if (pop_idle_pct != 0 && $urandom_range(99) < pop_idle_pct) begin
                pop_stall = $urandom_range(17, 1) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        clear_parser();
        // truncated after both SAPs, SNAP flagged
        add_frame('{SNAP_SAP, SNAP_SAP});
        // plain U format, one payload byte
        add_frame('{8'h00, 8'hFF, 8'h03, 8'h00});
        // plain S format, header ends on the final byte
        add_frame('{8'hFF, 8'h00, 8'h01, 8'hFF});
        // SNAP I format carrying EAPOL, payload 0xFF
        add_frame('{SNAP_SAP, SNAP_SAP, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                    TYPE_EAPOL[15:8], TYPE_EAPOL[7:0], 8'hFF});
        // SNAP U format carrying IPv4, header ends on the final byte
        drain_next = 1'b1;
        add_frame('{SNAP_SAP, SNAP_SAP, 8'h03, 8'hFF, 8'hFF, 8'hFF,
                    TYPE_IPV4[15:8], TYPE_IPV4[7:0]});
        drain_next = 1'b1;
        while (tx_bytes.size() < 1050)
            add_random_frame();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        while (tx_bytes.size() != 0 || pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
